### sv/rcmm_pkg.sv
package rcmm_pkg;

  // channel count and field widths
  localparam int CHANNELS  = 4;
  localparam int CH_W      = 2;
  localparam int TIME_W    = 32;
  localparam int WIDTH_W   = 12;
  localparam int TRIM_W    = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int SPEED_W   = 16;

  // item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // channel codes
  localparam logic [CH_W-1:0] CH_POWER   = 2'd0;
  localparam logic [CH_W-1:0] CH_FORWARD = 2'd1;
  localparam logic [CH_W-1:0] CH_LATERAL = 2'd2;
  localparam logic [CH_W-1:0] CH_ROTATE  = 2'd3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIM_FORWARD  = 3'd0,
    REG_TRIM_LATERAL  = 3'd1,
    REG_TRIM_ROTATE   = 3'd2,
    REG_DEADBAND_LOW  = 3'd3,
    REG_DEADBAND_HIGH = 3'd4
  } cfg_reg_t;

  // pulse width constants in microseconds
  localparam logic [WIDTH_W-1:0] MID_US    = 12'd1500;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 12'd4095;

  // rotate gain 2461/500: multiply by the numerator, then divide by 500
  // through a reciprocal, exact for dividends below 2^23
  localparam logic signed [12:0] ROT_NUM     = 13'sd2461;
  localparam int                 ROT_MAG_W   = 23;
  localparam int                 RECIP_SHIFT = 32;
  localparam logic [23:0]        RECIP_500   = 24'd8589935;

  // wheels with reversed polarity: right front and right rear
  localparam logic [3:0] REVERSED_MASK = 4'b1010;

  typedef struct packed {
    logic [TRIM_W-1:0]  trim_forward;
    logic [TRIM_W-1:0]  trim_lateral;
    logic [TRIM_W-1:0]  trim_rotate;
    logic [WIDTH_W-1:0] deadband_low;
    logic [WIDTH_W-1:0] deadband_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    trim_forward:  8'd7,
    trim_lateral:  8'd20,
    trim_rotate:   8'd20,
    deadband_low:  12'd1490,
    deadband_high: 12'd1510
  };

  // axis values after width scaling, rotate not yet divided
  typedef struct packed {
    logic               power;
    logic signed [15:0] fwd;
    logic signed [15:0] lat;
    logic signed [23:0] rot_prod;
  } axis_t;

  // axis values ready for mixing
  typedef struct packed {
    logic               power;
    logic signed [15:0] fwd;
    logic signed [15:0] lat;
    logic signed [15:0] rot;
  } mix_t;

endpackage

### sv/rcmm_if.sv
interface rcmm_in_if import rcmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CH_W-1:0]   channel;
  logic              level;
  logic [TIME_W-1:0] time_us;

  modport source(output valid, kind, channel, level, time_us, input ready);
  modport sink(input valid, kind, channel, level, time_us, output ready);
endinterface

interface rcmm_out_if import rcmm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_left_front;
  logic [SPEED_W-1:0] speed_right_front;
  logic [SPEED_W-1:0] speed_left_rear;
  logic [SPEED_W-1:0] speed_right_rear;
  logic [3:0]         direction_bits;
  logic [3:0]         enable_bits;

  modport source(output valid, speed_left_front, speed_right_front, speed_left_rear,
                 speed_right_rear, direction_bits, enable_bits, input ready);
  modport sink(input valid, speed_left_front, speed_right_front, speed_left_rear,
               speed_right_rear, direction_bits, enable_bits, output ready);
endinterface

### sv/rcmm_pulse_timer.sv
module rcmm_pulse_timer import rcmm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  rcmm_in_if.sink item,
  input  cfg_t  cfg,
  output logic  axis_valid,
  output axis_t axis,
  input  logic  axis_ready
);

  // input register
  logic              v0;
  logic              kind0;
  logic [CH_W-1:0]   ch0;
  logic              level0;
  logic [TIME_W-1:0] time0;

  // pulse state
  logic [TIME_W-1:0]  rise_time [CHANNELS];
  logic [WIDTH_W-1:0] width [CHANNELS];

  logic               take_tick;
  logic               fire0;
  logic [TIME_W-1:0]  elapsed;
  logic [TRIM_W-1:0]  trim_sel;
  logic [TIME_W:0]    width_sum;
  logic [WIDTH_W-1:0] width_sat;
  logic signed [12:0] diff_f;
  logic signed [12:0] diff_l;
  logic signed [12:0] diff_r;
  logic signed [25:0] rot_full;
  axis_t              axis_next;

  function automatic logic is_neutral(logic [WIDTH_W-1:0] w, cfg_t c);
    return (w > c.deadband_low) && (w < c.deadband_high);
  endfunction

  // edges always retire; a tick needs room in the next stage
  assign take_tick  = v0 && (kind0 == KIND_TICK) && (!axis_valid || axis_ready);
  assign fire0      = v0 && ((kind0 == KIND_EDGE) || take_tick);
  assign item.ready = !v0 || fire0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (item.ready) begin
      v0 <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      kind0  <= item.kind;
      ch0    <= item.channel;
      level0 <= item.level;
      time0  <= item.time_us;
    end
  end

  // per-channel trim
  always_comb begin
    case (ch0)
      CH_FORWARD: trim_sel = cfg.trim_forward;
      CH_LATERAL: trim_sel = cfg.trim_lateral;
      CH_ROTATE:  trim_sel = cfg.trim_rotate;
      default:    trim_sel = '0;
    endcase
  end

  // measured width plus trim, saturated
  assign elapsed   = time0 - rise_time[ch0];
  assign width_sum = {1'b0, elapsed} + (TIME_W+1)'(trim_sel);
  assign width_sat = (width_sum > (TIME_W+1)'(WIDTH_MAX)) ? WIDTH_MAX
                                                          : width_sum[WIDTH_W-1:0];

  // width state: edges update, a tick returns to failsafe
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_time[i] <= '0;
        width[i]     <= (i == int'(CH_POWER)) ? '0 : MID_US;
      end
    end else if (fire0) begin
      if (kind0 == KIND_EDGE) begin
        if (level0) begin
          rise_time[ch0] <= time0;
        end else begin
          width[ch0] <= width_sat;
        end
      end else begin
        for (int i = 0; i < CHANNELS; i++) begin
          width[i] <= (i == int'(CH_POWER)) ? '0 : MID_US;
        end
      end
    end
  end

  // axis scaling from the stored widths
  assign diff_f   = $signed({1'b0, width[CH_FORWARD]}) - 13'sd1500;
  assign diff_l   = $signed({1'b0, width[CH_LATERAL]}) - 13'sd1500;
  assign diff_r   = $signed({1'b0, width[CH_ROTATE]}) - 13'sd1500;
  assign rot_full = diff_r * ROT_NUM;

  always_comb begin
    axis_next.power    = width[CH_POWER] > MID_US;
    axis_next.fwd      = is_neutral(width[CH_FORWARD], cfg) ? 16'sd0 : {diff_f, 3'b000};
    axis_next.lat      = is_neutral(width[CH_LATERAL], cfg) ? 16'sd0 : {diff_l, 3'b000};
    axis_next.rot_prod = is_neutral(width[CH_ROTATE], cfg) ? 24'sd0 : rot_full[23:0];
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_valid <= 1'b0;
    end else if (!axis_valid || axis_ready) begin
      axis_valid <= take_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      axis <= axis_next;
    end
  end

  // a tick leaves the widths at failsafe
  assert property (@(posedge clk) disable iff (rst)
    take_tick |=> (width[CH_POWER] == '0) && (width[CH_FORWARD] == MID_US) &&
                  (width[CH_LATERAL] == MID_US) && (width[CH_ROTATE] == MID_US))
    else $error("widths not returned to failsafe after tick");

endmodule

### sv/rcmm_rot_scale.sv
module rcmm_rot_scale import rcmm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  axis_valid,
  input  axis_t axis,
  output logic  axis_ready,
  output logic  mix_valid,
  output mix_t  mix,
  input  logic  mix_ready
);

  logic                     neg;
  logic [23:0]              neg_prod;
  logic [ROT_MAG_W-1:0]     mag;
  logic [ROT_MAG_W+23:0]    quot_full;
  logic [14:0]              quot;
  mix_t                     mix_next;

  assign axis_ready = !mix_valid || mix_ready;

  // divide by 500 toward zero: magnitude times reciprocal, sign restored
  assign neg       = axis.rot_prod[23];
  assign neg_prod  = -axis.rot_prod;
  assign mag       = neg ? neg_prod[ROT_MAG_W-1:0] : axis.rot_prod[ROT_MAG_W-1:0];
  assign quot_full = (ROT_MAG_W+24)'(mag) * (ROT_MAG_W+24)'(RECIP_500);
  assign quot      = quot_full[RECIP_SHIFT+14:RECIP_SHIFT];

  always_comb begin
    mix_next.power = axis.power;
    mix_next.fwd   = axis.fwd;
    mix_next.lat   = axis.lat;
    mix_next.rot   = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (axis_ready) begin
      mix_valid <= axis_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (axis_valid && axis_ready) begin
      mix <= mix_next;
    end
  end

  // rotate axis stays within the scaled width range
  assert property (@(posedge clk) disable iff (rst)
    mix_valid |-> (mix.rot >= -16'sd7383) && (mix.rot <= 16'sd12772))
    else $error("rotate axis out of range");

endmodule

### sv/rcmm_wheel_mix.sv
module rcmm_wheel_mix import rcmm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic mix_valid,
  input  mix_t mix,
  output logic mix_ready,
  rcmm_out_if.source result
);

  logic signed [16:0] f17;
  logic signed [16:0] l17;
  logic signed [16:0] r17;
  logic signed [16:0] sum [4];
  logic [16:0]        neg_sum [4];
  logic [SPEED_W-1:0] mag [4];
  logic [3:0]         dir_next;
  logic [3:0]         en_next;
  logic               load;

  // output register and direction state
  logic               out_valid;
  logic [SPEED_W-1:0] speed [4];
  logic [3:0]         enable_bits;
  logic [3:0]         wheel_direction;

  assign mix_ready = !out_valid || result.ready;
  assign load      = mix_valid && mix_ready;

  // wheel sums
  assign f17    = 17'(mix.fwd);
  assign l17    = 17'(mix.lat);
  assign r17    = 17'(mix.rot);
  assign sum[0] = f17 + l17 + r17;
  assign sum[1] = f17 - l17 - r17;
  assign sum[2] = f17 - l17 + r17;
  assign sum[3] = f17 + l17 - r17;

  // magnitude, direction and enable per wheel
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      neg_sum[i] = -sum[i];
      mag[i]     = sum[i][16] ? neg_sum[i][SPEED_W-1:0] : sum[i][SPEED_W-1:0];
      if (sum[i] != 17'sd0) begin
        dir_next[i] = sum[i][16] ^ REVERSED_MASK[i];
        en_next[i]  = mix.power;
      end else begin
        dir_next[i] = wheel_direction[i];
        en_next[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      wheel_direction <= '0;
    end else begin
      if (mix_ready) begin
        out_valid <= mix_valid;
      end
      if (load) begin
        wheel_direction <= dir_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        speed[i] <= mag[i];
      end
      enable_bits <= en_next;
    end
  end

  assign result.valid             = out_valid;
  assign result.speed_left_front  = speed[0];
  assign result.speed_right_front = speed[1];
  assign result.speed_left_rear   = speed[2];
  assign result.speed_right_rear  = speed[3];
  assign result.direction_bits    = wheel_direction;
  assign result.enable_bits       = enable_bits;

  // an enabled wheel always has a nonzero speed
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!enable_bits[0] || speed[0] != '0) && (!enable_bits[1] || speed[1] != '0) &&
                  (!enable_bits[2] || speed[2] != '0) && (!enable_bits[3] || speed[3] != '0))
    else $error("wheel enabled with zero speed");

  // power off gives no enables
  assert property (@(posedge clk) disable iff (rst)
    (load && !mix.power) |=> (enable_bits == '0))
    else $error("wheel enabled while power off");

endmodule

### sv/rc_pulse_mecanum_mixer_core.sv
// RC pulse receiver and mecanum wheel mixer.
// item channel: valid/ready words carrying kind, channel, level and time_us.
//   An edge word (kind 0) times one servo channel and gives no result.
//   A tick word (kind 1) mixes the stored widths into one result word and
//   returns the widths to failsafe (power 0, axes 1500 us).
// result channel: valid/ready words with four wheel speeds, direction bits
//   and enable bits.
// Config: wr_en / wr_index / wr_data write the trims and the deadband bounds;
//   write only while no words are in flight.
// Path: a tick accepted on the item channel passes the input register, the
//   axis scaling stage, the rotate divide stage and the output register, where
//   its result is valid. Throughput is one word per cycle while the receiver keeps up.
// Reset (rst, synchronous): pipeline empty, widths at failsafe, rise times
//   and direction bits zero, registers at their defaults.
// When the receiver stalls, ticks queue in the three stages behind the
//   output register; edge words still retire from the input register, and
//   item.ready drops once a tick there finds the stages full.
module rc_pulse_mecanum_mixer_core import rcmm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rcmm_in_if.sink              item,
  rcmm_out_if.source           result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  cfg_t  cfg;
  logic  axis_valid;
  logic  axis_ready;
  axis_t axis;
  logic  mix_valid;
  logic  mix_ready;
  mix_t  mix;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_TRIM_FORWARD:  cfg.trim_forward  <= wr_data[TRIM_W-1:0];
        REG_TRIM_LATERAL:  cfg.trim_lateral  <= wr_data[TRIM_W-1:0];
        REG_TRIM_ROTATE:   cfg.trim_rotate   <= wr_data[TRIM_W-1:0];
        REG_DEADBAND_LOW:  cfg.deadband_low  <= wr_data[WIDTH_W-1:0];
        REG_DEADBAND_HIGH: cfg.deadband_high <= wr_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  rcmm_pulse_timer u_timer (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .axis_valid (axis_valid),
    .axis       (axis),
    .axis_ready (axis_ready)
  );

  rcmm_rot_scale u_rot (
    .clk        (clk),
    .rst        (rst),
    .axis_valid (axis_valid),
    .axis       (axis),
    .axis_ready (axis_ready),
    .mix_valid  (mix_valid),
    .mix        (mix),
    .mix_ready  (mix_ready)
  );

  rcmm_wheel_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .mix_valid (mix_valid),
    .mix       (mix),
    .mix_ready (mix_ready),
    .result    (result)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rcmm_pkg::*;

  // mixer gains and run limits
  localparam int LIN_GAIN      = 8;
  localparam int ROT_GAIN_NUM  = 2461;
  localparam int ROT_GAIN_DEN  = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PERCENT  = 15;

  typedef struct packed {
    logic              kind;
    logic [CH_W-1:0]   channel;
    logic              level;
    logic [TIME_W-1:0] time_us;
  } pin_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] lf;
    logic [SPEED_W-1:0] rf;
    logic [SPEED_W-1:0] lr;
    logic [SPEED_W-1:0] rr;
    logic [3:0]         dir;
    logic [3:0]         en;
  } wheel_drive_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  rcmm_in_if  item_bus();
  rcmm_out_if result_bus();

  rc_pulse_mecanum_mixer_core dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_bus),
    .result   (result_bus),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // mirror of the receiver and mixer state
  cfg_t               shadow_cfg;
  logic [TIME_W-1:0]  rise_at   [CHANNELS];
  logic [WIDTH_W-1:0] width_us  [CHANNELS];
  logic [3:0]         wheel_dir;

  pin_word_t    pending_words[$];
  wheel_drive_t expected_drive[$];
  pin_word_t    on_bus;

  int  mismatch_count;
  int  words_taken;
  int  drives_checked;
  int  settings_used;
  int  words_pushed;
  int  cycle_count;
  int  hold_asked;
  int  hold_served;
  int  hold_left;
  logic quiet_stretch;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic logic [TRIM_W-1:0] trim_for(input logic [CH_W-1:0] ch);
    case (ch)
      CH_FORWARD: return shadow_cfg.trim_forward;
      CH_LATERAL: return shadow_cfg.trim_lateral;
      CH_ROTATE:  return shadow_cfg.trim_rotate;
      default:    return '0;
    endcase
  endfunction

  function automatic logic in_deadband(input logic [WIDTH_W-1:0] w);
    return (w > shadow_cfg.deadband_low) && (w < shadow_cfg.deadband_high);
  endfunction

  function automatic int linear_axis(input logic [WIDTH_W-1:0] w);
    int wi;
    wi = int'(w);
    if (in_deadband(w)) return 0;
    return (wi - int'(MID_US)) * LIN_GAIN;
  endfunction

  // signed division truncates toward zero
  function automatic int rotate_axis(input logic [WIDTH_W-1:0] w);
    int wi;
    wi = int'(w);
    if (in_deadband(w)) return 0;
    return ((wi - int'(MID_US)) * ROT_GAIN_NUM) / ROT_GAIN_DEN;
  endfunction

  // update the mirror with one accepted word, queue the wheel drive for ticks
  task automatic take_word(input pin_word_t w);
    logic [TIME_W-1:0] span;
    logic [TIME_W:0]   total;
    int                fwd, lat, rot, mag;
    int                sums[4];
    logic              powered, neg;
    wheel_drive_t      drive;
    logic [SPEED_W-1:0] mags[4];
    if (w.kind == KIND_EDGE) begin
      if (w.level) begin
        rise_at[w.channel] = w.time_us;
      end else begin
        span  = w.time_us - rise_at[w.channel];
        total = {1'b0, span} + (TIME_W+1)'(trim_for(w.channel));
        width_us[w.channel] = (total > WIDTH_MAX) ? WIDTH_MAX : total[WIDTH_W-1:0];
      end
    end else begin
      powered = width_us[CH_POWER] > MID_US;
      fwd = linear_axis(width_us[CH_FORWARD]);
      lat = linear_axis(width_us[CH_LATERAL]);
      rot = rotate_axis(width_us[CH_ROTATE]);
      sums[0] = fwd + lat + rot;
      sums[1] = fwd - lat - rot;
      sums[2] = fwd - lat + rot;
      sums[3] = fwd + lat - rot;
      drive.en = '0;
      for (int i = 0; i < 4; i++) begin
        mag = 0;
        if (sums[i] != 0) begin
          neg = sums[i] < 0;
          mag = neg ? -sums[i] : sums[i];
          // a zero sum leaves the direction bit alone
          wheel_dir[i] = neg ^ REVERSED_MASK[i];
          if (powered) drive.en[i] = 1'b1;
        end
        mags[i] = mag[SPEED_W-1:0];
      end
      drive.lf  = mags[0];
      drive.rf  = mags[1];
      drive.lr  = mags[2];
      drive.rr  = mags[3];
      drive.dir = wheel_dir;
      expected_drive.push_back(drive);
      // back to failsafe widths
      width_us[CH_POWER]   = '0;
      width_us[CH_FORWARD] = MID_US;
      width_us[CH_LATERAL] = MID_US;
      width_us[CH_ROTATE]  = MID_US;
    end
  endtask

  // driver: presents queued words, holds each until taken
  always @(posedge clk) begin
    logic holding;
    pin_word_t nxt;
    if (rst) begin
      item_bus.valid <= 1'b0;
      wheel_dir      = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rise_at[c]  = '0;
        width_us[c] = (c == int'(CH_POWER)) ? '0 : MID_US;
      end
    end else begin
      holding = item_bus.valid;
      if (item_bus.valid && item_bus.ready) begin
        take_word(on_bus);
        words_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (pending_words.size() > 0 &&
            (quiet_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          nxt = pending_words.pop_front();
          on_bus = nxt;
          item_bus.valid   <= 1'b1;
          item_bus.kind    <= nxt.kind;
          item_bus.channel <= nxt.channel;
          item_bus.level   <= nxt.level;
          item_bus.time_us <= nxt.time_us;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("drive %0d %s got %0d want %0d",
                                drives_checked, name, got, want));
  endtask

  // monitor: checks each result word, drives ready with random stalls
  always @(posedge clk) begin
    wheel_drive_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_drive.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_drive.pop_front();
          check_field("speed_left_front",  int'(result_bus.speed_left_front),
                      int'(want.lf));
          check_field("speed_right_front", int'(result_bus.speed_right_front),
                      int'(want.rf));
          check_field("speed_left_rear",   int'(result_bus.speed_left_rear),
                      int'(want.lr));
          check_field("speed_right_rear",  int'(result_bus.speed_right_rear),
                      int'(want.rr));
          check_field("direction_bits",    int'(result_bus.direction_bits),
                      int'(want.dir));
          check_field("enable_bits",       int'(result_bus.enable_bits),
                      int'(want.en));
        end
        drives_checked++;
      end
      // long hold-off on request, counted here
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  function automatic void push_word(input logic kind, input logic [CH_W-1:0] ch,
                                    input logic level, input logic [TIME_W-1:0] t);
    pin_word_t w;
    w.kind    = kind;
    w.channel = ch;
    w.level   = level;
    w.time_us = t;
    pending_words.push_back(w);
    words_pushed++;
  endfunction

  function automatic void push_tick();
    push_word(KIND_TICK, CH_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
  endfunction

  // pulse length before trim, spread over the interesting ranges
  function automatic logic [TIME_W-1:0] pick_width(input logic [CH_W-1:0] ch);
    int trim;
    trim = int'(trim_for(ch));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return TIME_W'($urandom_range(900, 2100));
      4:          return TIME_W'($urandom_range(1460, 1540));
      5:          return TIME_W'(int'(shadow_cfg.deadband_low) - trim + $urandom_range(0, 6) - 3);
      6:          return TIME_W'(int'(shadow_cfg.deadband_high) - trim + $urandom_range(0, 6) - 3);
      7:          return TIME_W'($urandom_range(0, 40));
      8:          return TIME_W'($urandom_range(3900, 4300));
      default:    return $urandom;
    endcase
  endfunction

  // one transmitter frame: pulses on some channels, then a tick
  function automatic void push_frame();
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] widths[CHANNELS];
    logic [TIME_W-1:0] offs[CHANNELS];
    logic              used[CHANNELS];
    logic              interleave;
    int                flaw;
    if ($urandom_range(0, 4) == 0) base = 32'hFFFF_F000 + $urandom_range(0, 4095);
    else base = $urandom;
    interleave = 1'($urandom_range(0, 1));
    for (int c = 0; c < CHANNELS; c++) begin
      used[c]   = $urandom_range(0, 99) < 85;
      widths[c] = pick_width(CH_W'(c));
      offs[c]   = $urandom_range(0, 300);
    end
    // broken frames: a missing rise or a doubled rise
    flaw = $urandom_range(0, 9);
    for (int c = 0; c < CHANNELS; c++) begin
      if (used[c]) begin
        if (!(flaw == 0 && c == 1)) push_word(KIND_EDGE, CH_W'(c), 1'b1, base + offs[c]);
        if (flaw == 1 && c == 3) push_word(KIND_EDGE, CH_W'(c), 1'b1, base + offs[c] + 5);
        if (!interleave) begin
          push_word(KIND_EDGE, CH_W'(c), 1'b0, base + offs[c] + widths[c]);
          base = base + widths[c] + offs[c];
        end
      end
    end
    if (interleave) begin
      for (int c = 0; c < CHANNELS; c++)
        if (used[c]) push_word(KIND_EDGE, CH_W'(c), 1'b0, base + offs[c] + widths[c]);
    end
    push_tick();
  endfunction

  task automatic run_random(input int count);
    int start;
    @(negedge clk);
    start = words_pushed;
    while (words_pushed - start < count) begin
      if ($urandom_range(0, 99) < 15)
        push_word(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), $urandom);
      else
        push_frame();
    end
  endtask

  // wait until every word is taken and every drive checked, then settle
  task automatic wait_drained();
    while (!(pending_words.size() == 0 && !item_bus.valid && expected_drive.size() == 0))
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    case (idx)
      REG_TRIM_FORWARD:  shadow_cfg.trim_forward  = value[TRIM_W-1:0];
      REG_TRIM_LATERAL:  shadow_cfg.trim_lateral  = value[TRIM_W-1:0];
      REG_TRIM_ROTATE:   shadow_cfg.trim_rotate   = value[TRIM_W-1:0];
      REG_DEADBAND_LOW:  shadow_cfg.deadband_low  = value[WIDTH_W-1:0];
      REG_DEADBAND_HIGH: shadow_cfg.deadband_high = value[WIDTH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // trims carry random upper bits, which the block must drop
  task automatic write_setting(input int tf, input int tl, input int tr,
                               input int lo, input int hi);
    write_reg(REG_TRIM_FORWARD, {4'($urandom), 8'(tf)});
    write_reg(REG_TRIM_LATERAL, {4'($urandom), 8'(tl)});
    write_reg(REG_TRIM_ROTATE,  {4'($urandom), 8'(tr)});
    write_reg(REG_DEADBAND_LOW,  12'(lo));
    write_reg(REG_DEADBAND_HIGH, 12'(hi));
    settings_used++;
  endtask

  // stimulus
  initial begin
    rst              = 1'b1;
    wr_en            = 1'b0;
    wr_index         = '0;
    wr_data          = '0;
    quiet_stretch    = 1'b0;
    settings_used    = 1;
    words_pushed     = 0;
    hold_asked       = 0;
    shadow_cfg       = CFG_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed words under reset settings
    @(negedge clk);
    push_tick();                                            // failsafe widths
    push_word(KIND_EDGE, CH_POWER, 1'b1, 32'd100);
    push_word(KIND_EDGE, CH_POWER, 1'b0, 32'd2100);
    push_word(KIND_EDGE, CH_FORWARD, 1'b1, 32'hFFFF_FF00);  // timestamp wraps
    push_word(KIND_EDGE, CH_FORWARD, 1'b0, 32'h0000_0400);
    push_word(KIND_EDGE, CH_LATERAL, 1'b0, 32'd1980);       // fall with no rise
    push_word(KIND_EDGE, CH_ROTATE, 1'b1, 32'd5000);
    push_word(KIND_EDGE, CH_ROTATE, 1'b1, 32'd6000);        // newer rise wins
    push_word(KIND_EDGE, CH_ROTATE, 1'b0, 32'd8000);
    push_word(KIND_TICK, CH_ROTATE, 1'b1, 32'hFFFF_FFFF);   // tick fields ignored
    push_word(KIND_TICK, CH_POWER, 1'b0, 32'd0);            // all zero sums keep bits
    push_word(KIND_EDGE, CH_FORWARD, 1'b1, 32'd0);
    push_word(KIND_EDGE, CH_FORWARD, 1'b0, 32'hFFFF_FFFF);  // saturates
    push_word(KIND_EDGE, CH_ROTATE, 1'b1, 32'd77);
    push_word(KIND_EDGE, CH_ROTATE, 1'b0, 32'd77);          // zero length
    push_word(KIND_EDGE, CH_LATERAL, 1'b1, 32'd10);
    push_word(KIND_EDGE, CH_LATERAL, 1'b0, 32'd1480);       // on the low bound
    push_word(KIND_EDGE, CH_POWER, 1'b1, 32'd0);
    push_word(KIND_EDGE, CH_POWER, 1'b0, 32'd1500);         // power just off
    push_tick();
    push_word(KIND_EDGE, CH_FORWARD, 1'b1, 32'd0);
    push_word(KIND_EDGE, CH_FORWARD, 1'b0, 32'd1484);       // just inside deadband
    push_word(KIND_EDGE, CH_LATERAL, 1'b1, 32'd0);
    push_word(KIND_EDGE, CH_LATERAL, 1'b0, 32'd1490);       // on the high bound
    push_word(KIND_EDGE, CH_POWER, 1'b1, 32'd0);
    push_word(KIND_EDGE, CH_POWER, 1'b0, 32'd1501);         // power just on
    push_tick();
    wait_drained();

    // zero trims, widest deadband
    write_setting(0, 0, 0, 0, 4095);
    run_random(100);
    wait_drained();

    // full trims, crossed deadband bounds
    write_setting(255, 255, 255, 4095, 0);
    run_random(100);
    wait_drained();

    // long receiver hold-off with the sender never idle, pipeline fills up
    write_setting($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(1400, 1499), $urandom_range(1501, 1600));
    @(negedge clk);
    quiet_stretch = 1'b1;
    hold_asked    = hold_asked + 1;
    for (int i = 0; i < 8; i++) push_tick();
    run_random(110);
    wait_drained();
    quiet_stretch = 1'b0;

    // equal deadband bounds, random trims
    write_setting($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  1500, 1500);
    run_random(100);
    wait_drained();

    $display("covered %0d input words and %0d wheel drive words", words_taken, drives_checked);
    $display("over %0d register settings, with %0d mismatches", settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### rc_pulse_mecanum_mixer_core.f
sv/rcmm_pkg.sv
sv/rcmm_if.sv
sv/rcmm_pulse_timer.sv
sv/rcmm_rot_scale.sv
sv/rcmm_wheel_mix.sv
sv/rc_pulse_mecanum_mixer_core.sv
bench/testbench.sv
